// File: rtl/core/cssq_pkg.sv
// Shared types and constants for the climate sensor state qualifier.
package cssq_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int DEV_WIDTH    = SAMPLE_WIDTH - 1;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = SAMPLE_WIDTH;
    localparam int COUNT_W      = 8;

    // 99.0 percent and -128.0 degrees in Q12.4
    localparam logic signed [SAMPLE_WIDTH-1:0] HUM_MAX_Q  = SAMPLE_WIDTH'(1584);
    localparam logic signed [SAMPLE_WIDTH-1:0] TEMP_MIN_Q = SAMPLE_WIDTH'(-2048);

    typedef enum logic [1:0] {
        ST_NORMAL    = 2'd0,
        ST_HEAT_DRY  = 2'd1,
        ST_EMERGENCY = 2'd2
    } state_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_RANGE     = 2'd1,
        ERR_DEVIATION = 2'd2,
        ERR_HUMID_HOT = 2'd3
    } err_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEMP_UPPER_LIMIT   = 4'd0,
        REG_MAX_DEVIATION      = 4'd1,
        REG_POWER_ON_TEMP      = 4'd2,
        REG_HUMIDITY_UPPER     = 4'd3,
        REG_HUMIDITY_LIMIT_HOT = 4'd4,
        REG_TEMP_LIMIT_HUMID   = 4'd5,
        REG_HUMIDITY_ENABLE    = 4'd6,
        REG_SENSITIVITY        = 4'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] temp_upper_limit;
        logic        [DEV_WIDTH-1:0]    max_deviation;
        logic signed [SAMPLE_WIDTH-1:0] power_on_temp;
        logic signed [SAMPLE_WIDTH-1:0] humidity_upper;
        logic signed [SAMPLE_WIDTH-1:0] humidity_limit_hot;
        logic signed [SAMPLE_WIDTH-1:0] temp_limit_humid;
        logic                           humidity_enable;
        logic        [COUNT_W-1:0]      sensitivity;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] temp_main;
        logic signed [SAMPLE_WIDTH-1:0] humidity;
        logic signed [SAMPLE_WIDTH-1:0] temp_probe_one;
        logic signed [SAMPLE_WIDTH-1:0] temp_probe_two;
        logic signed [SAMPLE_WIDTH-1:0] temp_combined;
        logic                           feedback_emergency;
    } sample_t;

    // raw classification of one sample set
    typedef struct packed {
        state_t cand;
        err_t   err;
        logic   err_load;   // low when the flag forces emergency: keep old code
    } class_t;

    typedef struct packed {
        state_t chosen;
        state_t cand;
        err_t   err;
    } res_t;

endpackage

// File: rtl/core/cssq_if.sv
// Channel interfaces: sample input, result output and configuration write.
interface cssq_sample_if import cssq_pkg::*;;
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] temp_main;
    logic signed [SAMPLE_WIDTH-1:0] humidity;
    logic signed [SAMPLE_WIDTH-1:0] temp_probe_one;
    logic signed [SAMPLE_WIDTH-1:0] temp_probe_two;
    logic signed [SAMPLE_WIDTH-1:0] temp_combined;
    logic                           feedback_emergency;

    modport source (output valid, temp_main, humidity, temp_probe_one, temp_probe_two,
                    temp_combined, feedback_emergency, input ready);
    modport sink   (input valid, temp_main, humidity, temp_probe_one, temp_probe_two,
                    temp_combined, feedback_emergency, output ready);
endinterface

interface cssq_result_if import cssq_pkg::*;;
    logic       valid;
    logic       ready;
    logic [1:0] chosen_state;
    logic [1:0] candidate_state;
    logic [1:0] error_code;

    modport source (output valid, chosen_state, candidate_state, error_code, input ready);
    modport sink   (input valid, chosen_state, candidate_state, error_code, output ready);
endinterface

interface cssq_cfg_if import cssq_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/cssq_cfg_regs.sv
// Configuration register file with reset values.
module cssq_cfg_regs import cssq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    cssq_cfg_if.sink   cfg,
    output cfg_t       regs
);

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_TEMP_UPPER_LIMIT:   regs_next.temp_upper_limit   = cfg.data;
                REG_MAX_DEVIATION:      regs_next.max_deviation      = cfg.data[DEV_WIDTH-1:0];
                REG_POWER_ON_TEMP:      regs_next.power_on_temp      = cfg.data;
                REG_HUMIDITY_UPPER:     regs_next.humidity_upper     = cfg.data;
                REG_HUMIDITY_LIMIT_HOT: regs_next.humidity_limit_hot = cfg.data;
                REG_TEMP_LIMIT_HUMID:   regs_next.temp_limit_humid   = cfg.data;
                REG_HUMIDITY_ENABLE:    regs_next.humidity_enable    = cfg.data[0];
                REG_SENSITIVITY:        regs_next.sensitivity        = cfg.data[COUNT_W-1:0];
                default:                regs_next = regs_reg;   // unmapped index ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.temp_upper_limit   <= SAMPLE_WIDTH'(1360);
            regs_reg.max_deviation      <= DEV_WIDTH'(160);
            regs_reg.power_on_temp      <= SAMPLE_WIDTH'(80);
            regs_reg.humidity_upper     <= SAMPLE_WIDTH'(1280);
            regs_reg.humidity_limit_hot <= SAMPLE_WIDTH'(960);
            regs_reg.temp_limit_humid   <= SAMPLE_WIDTH'(480);
            regs_reg.humidity_enable    <= 1'b1;
            regs_reg.sensitivity        <= COUNT_W'(3);
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

// File: rtl/core/cssq_classifier.sv
// Combinational classification of one sample set into candidate state and error.
module cssq_classifier import cssq_pkg::*;
(
    input  sample_t smp,
    input  cfg_t    regs,
    output class_t  cls
);

    // fused temp minus sensor temp, one bit wider so it never wraps
    function automatic logic dev_exceeds(
        input logic signed [SAMPLE_WIDTH-1:0] tc,
        input logic signed [SAMPLE_WIDTH-1:0] t,
        input logic        [DEV_WIDTH-1:0]    dev
    );
        logic signed [SAMPLE_WIDTH:0] diff;
        logic signed [SAMPLE_WIDTH:0] lim;
        diff = {tc[SAMPLE_WIDTH-1], tc} - {t[SAMPLE_WIDTH-1], t};
        lim  = {2'b00, dev};
        return diff > lim;
    endfunction

    function automatic logic temp_out(
        input logic signed [SAMPLE_WIDTH-1:0] t,
        input logic signed [SAMPLE_WIDTH-1:0] up
    );
        return (t > up) || (t < TEMP_MIN_Q);
    endfunction

    logic hen;
    logic range_err;
    logic dev_err;
    logic heat;
    logic hot_humid;

    assign hen = regs.humidity_enable;

    assign range_err = (hen && ((smp.humidity > HUM_MAX_Q) ||
                                (smp.humidity <= SAMPLE_WIDTH'(0)))) ||
                       temp_out(smp.temp_main,      regs.temp_upper_limit) ||
                       temp_out(smp.temp_probe_one, regs.temp_upper_limit) ||
                       temp_out(smp.temp_probe_two, regs.temp_upper_limit);

    assign dev_err = dev_exceeds(smp.temp_combined, smp.temp_probe_one, regs.max_deviation) ||
                     dev_exceeds(smp.temp_combined, smp.temp_main,      regs.max_deviation) ||
                     dev_exceeds(smp.temp_combined, smp.temp_probe_two, regs.max_deviation);

    assign heat = (smp.temp_main      < regs.power_on_temp) ||
                  (smp.temp_probe_one < regs.power_on_temp) ||
                  (smp.temp_probe_two < regs.power_on_temp) ||
                  (hen && (smp.humidity > regs.humidity_upper));

    assign hot_humid = hen && (smp.humidity > regs.humidity_limit_hot) &&
                       ((smp.temp_main      > regs.temp_limit_humid) ||
                        (smp.temp_probe_one > regs.temp_limit_humid) ||
                        (smp.temp_probe_two > regs.temp_limit_humid));

    always_comb
    begin
        cls.err_load = 1'b1;
        if (smp.feedback_emergency)
        begin
            cls.cand     = ST_EMERGENCY;
            cls.err      = ERR_NONE;
            cls.err_load = 1'b0;
        end
        else if (range_err)
        begin
            cls.cand = ST_EMERGENCY;
            cls.err  = ERR_RANGE;
        end
        else if (dev_err)
        begin
            cls.cand = ST_EMERGENCY;
            cls.err  = ERR_DEVIATION;
        end
        else if (hot_humid)
        begin
            cls.cand = ST_EMERGENCY;
            cls.err  = ERR_HUMID_HOT;
        end
        else
        begin
            cls.cand = heat ? ST_HEAT_DRY : ST_NORMAL;
            cls.err  = ERR_NONE;
        end
    end

endmodule

// File: rtl/core/cssq_qualifier.sv
// Repeat qualification of candidate states and error code tracking.
module cssq_qualifier import cssq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  class_t             cls,
    input  logic [COUNT_W-1:0] sensitivity,
    output res_t               res
);

    state_t             prev_reg,    prev_next;
    logic [COUNT_W-1:0] count_reg,   count_next;
    state_t             adopted_reg, adopted_next;
    err_t               err_reg,     err_next;

    logic [COUNT_W:0]   sens_plus_one;
    logic               repeat_cand;

    assign sens_plus_one = {1'b0, sensitivity} + (COUNT_W+1)'(1);
    assign repeat_cand   = (cls.cand == prev_reg);

    always_comb
    begin
        prev_next    = prev_reg;
        count_next   = count_reg;
        adopted_next = adopted_reg;
        err_next     = cls.err_load ? cls.err : err_reg;
        res.chosen   = adopted_reg;
        if (!repeat_cand)
        begin
            prev_next  = cls.cand;
            count_next = '0;
        end
        else
        begin
            // saturates at sensitivity+1 and at all ones
            if (({1'b0, count_reg} < sens_plus_one) && (count_reg != '1))
                count_next = count_reg + COUNT_W'(1);
            if (count_next == sensitivity)
            begin
                adopted_next = cls.cand;
                res.chosen   = cls.cand;
            end
        end
        res.cand = cls.cand;
        res.err  = err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg    <= ST_NORMAL;
            count_reg   <= '0;
            adopted_reg <= ST_NORMAL;
            err_reg     <= ERR_NONE;
        end
        else if (advance)
        begin
            prev_reg    <= prev_next;
            count_reg   <= count_next;
            adopted_reg <= adopted_next;
            err_reg     <= err_next;
        end
    end

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(adopted_reg) && $stable(count_reg) && $stable(prev_reg))
        else $error("qualifier state moved without a transaction");

    a_adopt_matches_prev: assert property (@(posedge clk) disable iff (!rst_n)
        adopted_reg != $past(adopted_reg) |-> adopted_reg == prev_reg)
        else $error("adopted state differs from the repeated candidate");

    a_change_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !repeat_cand |=> count_reg == '0)
        else $error("repeat count not cleared on candidate change");

endmodule

// File: rtl/core/climate_sensor_state_qualifier_unit.sv
// Top level of the climate sensor state qualifier.
// Each sample set is classified as normal, heating-and-drying or emergency and
// qualified: a candidate is adopted once it has repeated "sensitivity" times in a
// row, and until then the last adopted state is reported as chosen_state. One
// result transaction follows every sample transaction. Throughput is one sample per
// cycle while results are taken; a sample passes the input register, then the
// result register, with the classification compares and the repeat counter between
// them. The result register lets the next sample enter while a finished result waits
// for its taker. Config writes are taken every cycle (ready is tied high) and belong
// in idle periods; an index outside the eight defined registers is ignored.
module climate_sensor_state_qualifier_unit import cssq_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    cssq_sample_if.sink   sample,
    cssq_result_if.source result,
    cssq_cfg_if.sink      cfg
);

    cfg_t    regs;
    class_t  cls;
    res_t    res;

    // input stage
    logic    s1_valid_reg, s1_valid_next;
    sample_t s1_reg;
    // result stage
    logic    out_valid_reg, out_valid_next;
    res_t    out_reg;

    logic    in_xact;
    logic    out_free;
    logic    s1_adv;

    assign out_free     = !out_valid_reg || result.ready;
    assign s1_adv       = s1_valid_reg && out_free;
    assign sample.ready = !s1_valid_reg || out_free;
    assign in_xact      = sample.valid && sample.ready;

    assign s1_valid_next  = in_xact ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_adv ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);

    cssq_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    cssq_classifier u_cls (
        .smp  (s1_reg),
        .regs (regs),
        .cls  (cls)
    );

    // qualifier state commits when the sample moves into the result register
    cssq_qualifier u_qual (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (s1_adv),
        .cls         (cls),
        .sensitivity (regs.sensitivity),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xact)
        begin
            s1_reg.temp_main          <= sample.temp_main;
            s1_reg.humidity           <= sample.humidity;
            s1_reg.temp_probe_one     <= sample.temp_probe_one;
            s1_reg.temp_probe_two     <= sample.temp_probe_two;
            s1_reg.temp_combined      <= sample.temp_combined;
            s1_reg.feedback_emergency <= sample.feedback_emergency;
        end
        if (s1_adv)
            out_reg <= res;
    end

    assign result.valid           = out_valid_reg;
    assign result.chosen_state    = out_reg.chosen;
    assign result.candidate_state = out_reg.cand;
    assign result.error_code      = out_reg.err;

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !result.ready |-> !sample.ready)
        else $error("sample taken while both stages are blocked");

    a_heat_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.candidate_state == ST_HEAT_DRY |->
            result.error_code == ERR_NONE)
        else $error("heating-and-drying reported with an error code");

    a_error_is_emergency: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.error_code != ERR_NONE |->
            result.candidate_state == ST_EMERGENCY)
        else $error("error code set without emergency candidate");

endmodule

// File: verif/qualifier_check_pkg.sv
// Scoreboard class: predicts and checks the qualified state for each sample transaction.
package qualifier_check_pkg;
    import cssq_pkg::*;

    class qualifier_scoreboard;
        cfg_t               cfg;
        state_t             last_cand;
        logic [COUNT_W-1:0] repeat_cnt;
        state_t             adopted;
        err_t               last_err;
        res_t               state_verdicts[$];
        int                 error_count;

        function new();
            cfg.temp_upper_limit   = SAMPLE_WIDTH'(1360);
            cfg.max_deviation      = DEV_WIDTH'(160);
            cfg.power_on_temp      = SAMPLE_WIDTH'(80);
            cfg.humidity_upper     = SAMPLE_WIDTH'(1280);
            cfg.humidity_limit_hot = SAMPLE_WIDTH'(960);
            cfg.temp_limit_humid   = SAMPLE_WIDTH'(480);
            cfg.humidity_enable    = 1'b1;
            cfg.sensitivity        = COUNT_W'(3);
            last_cand   = ST_NORMAL;
            repeat_cnt  = '0;
            adopted     = ST_NORMAL;
            last_err    = ERR_NONE;
            error_count = 0;
        endfunction

        // unknown indexes are dropped, values masked to register width
        function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_TEMP_UPPER_LIMIT:   cfg.temp_upper_limit   = data;
                REG_MAX_DEVIATION:      cfg.max_deviation      = data[DEV_WIDTH-1:0];
                REG_POWER_ON_TEMP:      cfg.power_on_temp      = data;
                REG_HUMIDITY_UPPER:     cfg.humidity_upper     = data;
                REG_HUMIDITY_LIMIT_HOT: cfg.humidity_limit_hot = data;
                REG_TEMP_LIMIT_HUMID:   cfg.temp_limit_humid   = data;
                REG_HUMIDITY_ENABLE:    cfg.humidity_enable    = data[0];
                REG_SENSITIVITY:        cfg.sensitivity        = data[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function res_t qualify(sample_t s);
            int     t0, t1, t2, tc, hum, up, dev, pwr, hup, hhot, thum;
            bit     hen, range_bad;
            state_t cand;
            res_t   r;
            t0   = $signed(s.temp_main);
            hum  = $signed(s.humidity);
            t1   = $signed(s.temp_probe_one);
            t2   = $signed(s.temp_probe_two);
            tc   = $signed(s.temp_combined);
            up   = $signed(cfg.temp_upper_limit);
            dev  = cfg.max_deviation;
            pwr  = $signed(cfg.power_on_temp);
            hup  = $signed(cfg.humidity_upper);
            hhot = $signed(cfg.humidity_limit_hot);
            thum = $signed(cfg.temp_limit_humid);
            hen  = cfg.humidity_enable;
            range_bad = (hen && (hum > HUM_MAX_Q || hum <= 0)) ||
                        t0 > up || t1 > up || t2 > up ||
                        t0 < TEMP_MIN_Q || t1 < TEMP_MIN_Q || t2 < TEMP_MIN_Q;
            if (s.feedback_emergency)
            begin
                cand = ST_EMERGENCY;    // error code stays as it was
            end
            else if (range_bad)
            begin
                cand     = ST_EMERGENCY;
                last_err = ERR_RANGE;
            end
            else if (tc - t1 > dev || tc - t0 > dev || tc - t2 > dev)
            begin
                cand     = ST_EMERGENCY;
                last_err = ERR_DEVIATION;
            end
            else
            begin
                if (t0 < pwr || t1 < pwr || t2 < pwr || (hen && hum > hup))
                    cand = ST_HEAT_DRY;
                else
                    cand = ST_NORMAL;
                last_err = ERR_NONE;
                if (hen && hum > hhot && (t0 > thum || t1 > thum || t2 > thum))
                begin
                    cand     = ST_EMERGENCY;
                    last_err = ERR_HUMID_HOT;
                end
            end

            if (cand != last_cand)
            begin
                last_cand  = cand;
                repeat_cnt = '0;
            end
            else
            begin
                if (int'(repeat_cnt) < int'(cfg.sensitivity) + 1 && repeat_cnt != '1)
                    repeat_cnt++;
                if (repeat_cnt == cfg.sensitivity)
                    adopted = cand;
            end
            r.chosen = adopted;
            r.cand   = cand;
            r.err    = last_err;
            return r;
        endfunction

        function void note_sample(sample_t s);
            state_verdicts.push_back(qualify(s));
        endfunction

        function int pending();
            return state_verdicts.size();
        endfunction

        task report(string what);
            error_count++;
            $display("MISMATCH %0d at %0t: %s", error_count, $time, what);
        endtask

        task check_result(logic [1:0] chosen, logic [1:0] cand, logic [1:0] err);
            res_t want;
            if (state_verdicts.size() == 0)
            begin
                report($sformatf("result with nothing pending: chosen=%0d cand=%0d err=%0d",
                                 chosen, cand, err));
                return;
            end
            want = state_verdicts.pop_front();
            if (chosen !== want.chosen)
                report($sformatf("chosen_state %0d, want %0d", chosen, want.chosen));
            if (cand !== want.cand)
                report($sformatf("candidate_state %0d, want %0d", cand, want.cand));
            if (err !== want.err)
                report($sformatf("error_code %0d, want %0d", err, want.err));
        endtask
    endclass

endpackage

// File: verif/tb.sv
// Testbench top: directed and random sample sets, register phases and result back-pressure.
module tb;
    import cssq_pkg::*;
    import qualifier_check_pkg::*;

    localparam int NUM_REGS    = 8;
    localparam int HOLD_CYCLES = 150;      // long receiver stall, fills the pipeline
    localparam int TAIL_CYCLES = 8;        // pipeline drain plus margin
    localparam int Q_MIN       = -(2 ** (SAMPLE_WIDTH - 1));
    localparam int Q_MAX       = 2 ** (SAMPLE_WIDTH - 1) - 1;

    // what a generated sample set is aimed at
    typedef enum int {
        GEN_NORMAL, GEN_HEAT, GEN_RANGE, GEN_DEVIATION, GEN_HUMID_HOT, GEN_FLAG, GEN_NOISE
    } gen_kind_t;

    logic clk;
    logic rst_n;
    logic hold_off = 1'b0;
    bit   hold_trigger = 1'b0;
    bit   tx_burst = 1'b0;
    bit   rx_burst = 1'b0;

    qualifier_scoreboard sb;

    cssq_sample_if sample_ch ();
    cssq_result_if result_ch ();
    cssq_cfg_if    cfg_ch ();

    climate_sensor_state_qualifier_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic int imin(int a, int b);
        return (a < b) ? a : b;
    endfunction

    function automatic int imax(int a, int b);
        return (a > b) ? a : b;
    endfunction

    // uniform in [lo, hi]; an empty range collapses to lo
    function automatic int pick(int lo, int hi);
        if (hi <= lo)
            return lo;
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // saturate to the Q12.4 sample range
    function automatic logic signed [SAMPLE_WIDTH-1:0] to_q(int v);
        return SAMPLE_WIDTH'(imin(imax(v, Q_MIN), Q_MAX));
    endfunction

    function automatic sample_t mk(int t0, int hum, int t1, int t2, int tc, bit flag);
        sample_t s;
        s.temp_main          = to_q(t0);
        s.humidity           = to_q(hum);
        s.temp_probe_one     = to_q(t1);
        s.temp_probe_two     = to_q(t2);
        s.temp_combined      = to_q(tc);
        s.feedback_emergency = flag;
        return s;
    endfunction

    // idle cycles before the next transaction; bursts with no idling come and go
    function automatic int draw_gap(inout bit burst);
        if ($urandom_range(0, 15) == 0)
            burst = !burst;
        return burst ? 0 : $urandom_range(0, 12);
    endfunction

    // Builds a sample set around the live thresholds: start from a comfortable
    // set, then push one value across the threshold that the kind aims at.
    function automatic sample_t make_sample(gen_kind_t kind);
        int          t[3];
        int          up, dev, pwr, hup, hhot, thum, base, h, tc, pos;
        bit          hen, flag;
        logic [95:0] noise;
        sample_t     s;
        up   = $signed(sb.cfg.temp_upper_limit);
        dev  = sb.cfg.max_deviation;
        pwr  = $signed(sb.cfg.power_on_temp);
        hup  = $signed(sb.cfg.humidity_upper);
        hhot = $signed(sb.cfg.humidity_limit_hot);
        thum = $signed(sb.cfg.temp_limit_humid);
        hen  = sb.cfg.humidity_enable;
        pos  = $urandom_range(0, 2);
        flag = 1'b0;
        base = pick(imax(TEMP_MIN_Q, pwr), up);
        foreach (t[i])
            t[i] = imin(imax(base + pick(-8, 8), TEMP_MIN_Q), up);
        h = pick(1, imin(HUM_MAX_Q, imin(hup, hhot)));
        case (kind)
            GEN_HEAT:
            begin
                if (hen && $urandom_range(0, 1))
                begin
                    // humid but kept below the hot-and-humid temperature
                    h = pick(hup + 1, HUM_MAX_Q);
                    foreach (t[i])
                        t[i] = imin(t[i], thum);
                end
                else
                begin
                    t[pos] = pick(TEMP_MIN_Q, pwr - 1);
                end
            end
            GEN_RANGE:
            begin
                case ($urandom_range(0, 3))
                    0:       t[pos] = pick(up + 1, Q_MAX);
                    1:       t[pos] = pick(Q_MIN, TEMP_MIN_Q - 1);
                    2:       h = pick(HUM_MAX_Q + 1, Q_MAX);
                    default: h = pick(Q_MIN, 0);
                endcase
            end
            GEN_HUMID_HOT:
            begin
                h      = pick(hhot + 1, HUM_MAX_Q);
                t[pos] = pick(thum + 1, up);
            end
            GEN_FLAG: flag = 1'b1;
            default: ;
        endcase
        tc = imin(t[0], imin(t[1], t[2]));
        if (kind == GEN_DEVIATION)
            tc = tc + dev + pick(1, 16);
        else
            tc = tc - pick(0, 4);
        s = mk(t[0], h, t[1], t[2], tc, flag);
        if (kind == GEN_NOISE || (kind == GEN_FLAG && $urandom_range(0, 1)))
        begin
            noise = {$urandom, $urandom, $urandom};
            s     = noise[$bits(sample_t)-1:0];
            if (kind == GEN_FLAG)
                s.feedback_emergency = 1'b1;
        end
        return s;
    endfunction

    // Offers one sample transaction and returns at the edge that accepts it.
    // valid stays high afterwards so back-to-back items never drop it.
    task automatic send_sample(sample_t s);
        int gap;
        gap = hold_off ? 0 : draw_gap(tx_burst);   // keep pushing while the sink stalls
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid              <= 1'b1;
        sample_ch.temp_main          <= s.temp_main;
        sample_ch.humidity           <= s.humidity;
        sample_ch.temp_probe_one     <= s.temp_probe_one;
        sample_ch.temp_probe_two     <= s.temp_probe_two;
        sample_ch.temp_combined      <= s.temp_combined;
        sample_ch.feedback_emergency <= s.feedback_emergency;
        do @(posedge clk); while (!sample_ch.ready);
        sb.note_sample(s);
    endtask

    // Runs of one kind, so that candidates repeat long enough to be adopted.
    task automatic send_random(int count);
        gen_kind_t kind;
        int        run_len;
        while (count > 0)
        begin
            kind    = gen_kind_t'($urandom_range(0, GEN_NOISE));
            run_len = pick(1, imin(12, int'(sb.cfg.sensitivity) + 3));
            for (int i = 0; i < run_len && count > 0; i++)
            begin
                send_sample(make_sample(kind));
                count--;
            end
        end
    endtask

    // Drops valid and waits until every sample transaction has its result back.
    task automatic finish_phase();
        sample_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= CFG_DATA_W'(value);
        do @(posedge clk); while (!cfg_ch.ready);
        sb.load_reg(idx, CFG_DATA_W'(value));
    endtask

    // Only called with the block idle.
    task automatic set_all(int upper, int dev, int pwr, int hum_up, int hum_hot,
                           int t_humid, int hum_en, int sens);
        write_reg(REG_TEMP_UPPER_LIMIT, upper);
        write_reg(REG_MAX_DEVIATION, dev);
        write_reg(REG_POWER_ON_TEMP, pwr);
        write_reg(REG_HUMIDITY_UPPER, hum_up);
        write_reg(REG_HUMIDITY_LIMIT_HOT, hum_hot);
        write_reg(REG_TEMP_LIMIT_HUMID, t_humid);
        write_reg(REG_HUMIDITY_ENABLE, hum_en);
        write_reg(REG_SENSITIVITY, sens);
        cfg_ch.valid <= 1'b0;
    endtask

    // Result side: random ready gaps, plus the long hold when it is active.
    initial
    begin : result_taker
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = draw_gap(rx_burst);
            if (gap > 0 || hold_off)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
                while (hold_off) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
            sb.check_result(result_ch.chosen_state, result_ch.candidate_state,
                            result_ch.error_code);
        end
    end

    // One long stall of the result side, counted here, while samples keep coming.
    initial
    begin : long_stall
        wait (hold_trigger);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin : watchdog
        #400000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin : stimulus
        sample_t comfort;
        rst_n                        = 1'b0;
        sample_ch.valid              = 1'b0;
        sample_ch.temp_main          = '0;
        sample_ch.humidity           = '0;
        sample_ch.temp_probe_one     = '0;
        sample_ch.temp_probe_two     = '0;
        sample_ch.temp_combined      = '0;
        sample_ch.feedback_emergency = 1'b0;
        result_ch.ready              = 1'b0;
        cfg_ch.valid                 = 1'b0;
        cfg_ch.index                 = '0;
        cfg_ch.data                  = '0;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part, reset thresholds, sensitivity 3 ----
        // 20 C, 50 %: adopted on the third repeat, count saturates on the fourth
        comfort = mk(320, 800, 320, 320, 320, 1'b0);
        repeat (4) send_sample(comfort);
        // heating-and-drying from each trigger, adopted on the fourth
        send_sample(mk(79, 800, 320, 320, 79, 1'b0));       // main temp below power-on
        send_sample(mk(320, 1281, 320, 320, 320, 1'b0));    // humidity above upper
        send_sample(mk(320, 800, 320, 79, 79, 1'b0));       // second probe cold
        send_sample(mk(320, 800, 79, 320, 79, 1'b0));       // first probe cold
        send_sample(mk(80, 1280, 80, 80, 80, 1'b0));        // exactly on both thresholds
        // humidity range edges
        send_sample(mk(320, 1585, 320, 320, 320, 1'b0));
        send_sample(mk(320, 1584, 320, 320, 320, 1'b0));
        send_sample(mk(320, 0, 320, 320, 320, 1'b0));
        send_sample(mk(320, 1, 320, 320, 320, 1'b0));
        // temperature range edges, low and high
        send_sample(mk(320, 800, -2048, 320, -2048, 1'b0));
        send_sample(mk(320, 800, 320, -2049, -2049, 1'b0));
        send_sample(mk(1360, 800, 1360, 1360, 1360, 1'b0));
        send_sample(mk(1361, 800, 1360, 1360, 1360, 1'b0));
        // fused temperature exactly at and one past the allowed excess
        send_sample(mk(320, 800, 320, 320, 480, 1'b0));
        send_sample(mk(320, 800, 320, 320, 481, 1'b0));
        // external flag: emergency, deviation code must survive
        send_sample(mk(320, 800, 320, 320, 320, 1'b1));
        // hot-and-humid, then humidity on the hot limit
        send_sample(mk(320, 961, 481, 320, 320, 1'b0));
        send_sample(mk(481, 960, 320, 320, 320, 1'b0));
        // excess wider than the sample width must not wrap
        send_sample(mk(-2048, 800, -2048, -2048, Q_MAX, 1'b0));
        // field extremes, then emergency adopted through the flag
        send_sample(mk(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0));
        send_sample(mk(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b1));
        send_sample(mk(0, 0, 0, 0, 0, 1'b1));
        send_sample(mk(320, 800, 320, 320, 320, 1'b1));

        // ---- random at reset thresholds, with the long result stall ----
        hold_trigger = 1'b1;
        send_random(40);
        finish_phase();

        // ---- widest limits, humidity checks off; upper bits test the masks ----
        set_all(Q_MAX, 'hFFFF, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 'h2, 'h101);
        send_random(25);
        finish_phase();

        // ---- narrowest limits, sensitivity 0; unused indexes must be ignored ----
        write_reg(CFG_IDX_W'(NUM_REGS), $urandom);
        write_reg('1, $urandom);
        set_all(Q_MIN, 0, Q_MAX, Q_MIN, Q_MIN, Q_MIN, 1, 0);
        send_random(15);
        finish_phase();

        // ---- sensitivity 255: a long normal run adopts at the count ceiling ----
        set_all(800, 32, 160, 1000, 1200, 400, 1, 255);
        repeat (258) send_sample(make_sample(GEN_NORMAL));
        send_random(10);
        finish_phase();

        // ---- random moderate thresholds ----
        set_all(pick(0, 2000), pick(0, 400), pick(-500, 500), pick(500, 1584),
                pick(500, 1584), pick(0, 1000), 1, pick(1, 6));
        send_random(30);
        finish_phase();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.error_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
